@@ rtl/core/vtd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtd_pkg
// Shared types, constants and helpers for the throttle dynamics step core.
// ----------------------------------------------------------------------------
package vtd_pkg;

  // Item field widths
  localparam int DT_W  = 16;
  localparam int THR_W = 26;
  localparam int STR_W = 18;
  localparam int SPD_W = 24;
  localparam int YAW_W = 25;

  // Shared arithmetic unit widths
  localparam int ALU_A_W = 64;
  localparam int ALU_B_W = 33;

  // Vehicle constants, Q0.32
  localparam logic [31:0] BRAKE_PER_MASS    = 32'd25769803;
  localparam logic [31:0] FRICTION_PER_MASS = 32'd8589935;
  localparam logic [31:0] DRAG_PER_MASS     = 32'd85899;

  // e^-1 in Q0.32
  localparam logic [30:0] EXP_NEG_ONE   = 31'd1580030169;
  // integer exponent at which e^-x flushes to zero
  localparam logic [11:0] EXP_K_MAX     = 12'd23;
  // just below pi/2, Q2.16
  localparam logic [16:0] TAN_ANGLE_MAX = 17'd102943;
  localparam logic [3:0]  EXP_TERMS     = 4'd12;
  localparam logic [3:0]  TRIG_TERMS    = 4'd10;

  // Register reset values
  localparam logic [24:0] THROTTLE_LIMIT_RST      = 25'd6553600;
  localparam logic [25:0] THROTTLE_SLEW_RST       = 26'd13107200;
  localparam logic [23:0] SPEED_LIMIT_RST         = 24'd983040;
  localparam logic [16:0] STEER_LIMIT_RST         = 17'd32768;
  localparam logic [19:0] STEER_SLEW_RST          = 20'd65536;
  localparam logic [19:0] INVERSE_WHEELBASE_RST   = 20'd43691;
  localparam logic [31:0] DRIVE_GAIN_PER_MASS_RST = 32'd21474836;
  localparam logic [19:0] SPEED_DECAY_RST         = 20'd52429;

  typedef enum logic [2:0] {
    REG_THROTTLE_LIMIT      = 3'd0,
    REG_THROTTLE_SLEW       = 3'd1,
    REG_SPEED_LIMIT         = 3'd2,
    REG_STEER_LIMIT         = 3'd3,
    REG_STEER_SLEW          = 3'd4,
    REG_INVERSE_WHEELBASE   = 3'd5,
    REG_DRIVE_GAIN_PER_MASS = 3'd6,
    REG_SPEED_DECAY         = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WAIT,
    ST_TH_MOVE,
    ST_ST_MOVE,
    ST_BASE,
    ST_EXP_X,
    ST_TAY_DIV,
    ST_TAY_ACC,
    ST_EXP_POW,
    ST_DRIVE,
    ST_BRAKE,
    ST_DRAG_A,
    ST_DRAG_B,
    ST_FRIC,
    ST_SPEED,
    ST_TRIG_SQ,
    ST_TRIG_DIV,
    ST_TRIG_ACC,
    ST_YAW_P,
    ST_YAW_Q,
    ST_DONE
  } seq_state_t;

  // Taylor divisor for term k: sine 2k(2k+1), cosine (2k-1)2k
  function automatic logic [8:0] trig_divisor(input logic cos_mode, input logic [3:0] k);
    logic [8:0] m;
    begin
      m = {4'b0, k, 1'b0};
      return cos_mode ? 9'(m * (m - 9'd1)) : 9'(m * (m + 9'd1));
    end
  endfunction

endpackage

@@ rtl/core/vtd_serial_alu.sv @@
// ----------------------------------------------------------------------------
// vtd_serial_alu
// Bit-serial multiply (one multiplier bit per cycle) and restoring divide
// (one quotient bit per cycle). Result holds until the next start.
// ----------------------------------------------------------------------------
module vtd_serial_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  vtd_pkg::alu_req_t           req,
  input  logic [vtd_pkg::ALU_A_W-1:0] a,     // multiplicand or dividend
  input  logic [vtd_pkg::ALU_B_W-1:0] b,     // multiplier or divisor
  output logic                        done,
  output logic [vtd_pkg::ALU_A_W-1:0] res
);
  import vtd_pkg::*;

  localparam logic [5:0] MUL_LAST = 6'(ALU_B_W - 1);
  localparam logic [5:0] DIV_LAST = 6'(ALU_A_W - 1);

  logic [ALU_A_W-1:0] mcand;
  logic [ALU_B_W-1:0] mplier;
  logic [ALU_A_W-1:0] work;
  logic [ALU_B_W-1:0] rem;
  logic [5:0]         cnt;
  alu_op_t            op;
  logic               busy;

  logic [ALU_B_W:0]   shifted;
  logic [ALU_B_W:0]   diff;
  logic               last;

  assign shifted = {rem, work[ALU_A_W-1]};
  assign diff    = shifted - {1'b0, mplier};
  assign last    = (op == ALU_MUL) ? (cnt == MUL_LAST) : (cnt == DIV_LAST);
  assign res     = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && last) begin
      busy <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op     <= req.op;
      mcand  <= a;
      mplier <= b;
      rem    <= '0;
      cnt    <= '0;
      work   <= (req.op == ALU_MUL) ? '0 : a;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (op == ALU_MUL) begin
        if (mplier[0]) begin
          work <= work + mcand;
        end
        mcand  <= {mcand[ALU_A_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[ALU_B_W-1:1]};
      end else begin
        if (!diff[ALU_B_W]) begin
          rem  <= diff[ALU_B_W-1:0];
          work <= {work[ALU_A_W-2:0], 1'b1};
        end else begin
          rem  <= shifted[ALU_B_W-1:0];
          work <= {work[ALU_A_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

@@ rtl/core/vehicle_throttle_dynamics_step_core.sv @@
// ----------------------------------------------------------------------------
// vehicle_throttle_dynamics_step_core
// One vehicle dynamics tick per input item: slew-limited throttle and
// steering, speed integration with drive/brake, drag and friction, yaw rate.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             contents (lsb first)
//  s_*      in   s_tvalid / s_tready   tick_seconds, throttle_command, steer_command
//  m_*      out  m_tvalid / m_tready   applied_throttle, applied_steer,
//                                      linear_speed, yaw_rate
//  apb      in   psel/penable/pwrite   eight config registers at 4*index
//
//  Items: one item at a time, taken only in the idle state. The shared
//  serial unit paces the work; the brake path skips the speed exponent.
//  Reset: config registers to defaults, throttle/steer/speed to zero.
//  Stalls: a finished result waits in the output register; the next item is
//  taken meanwhile and the core holds only at its final step if still full.
// ----------------------------------------------------------------------------
module vehicle_throttle_dynamics_step_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // tick_seconds[15:0], throttle_command[41:16],
                                 // steer_command[59:42]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // applied_throttle[25:0], applied_steer[43:26],
                                 // linear_speed[67:44], yaw_rate[92:68]
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vtd_pkg::*;

  // config registers
  logic [24:0] throttle_limit;
  logic [25:0] throttle_slew;
  logic [23:0] speed_limit;
  logic [16:0] steer_limit;
  logic [19:0] steer_slew;
  logic [19:0] inverse_wheelbase;
  logic [31:0] drive_gain_per_mass;
  logic [19:0] speed_decay;

  // vehicle state
  logic [THR_W-1:0] throttle_state;
  logic [STR_W-1:0] steer_state;
  logic [SPD_W-1:0] speed_state;

  // sequencer
  seq_state_t state, state_next;
  seq_state_t ret, ret_next;

  // working registers
  logic [DT_W-1:0]  dt;
  logic [THR_W-1:0] tcmd;
  logic [STR_W-1:0] scmd;
  logic [24:0]      base;
  logic [4:0]       kcnt;
  logic [15:0]      frac;
  logic signed [35:0] sum;
  logic [3:0]       nidx;
  logic             cos_mode;
  logic [31:0]      a2;
  logic [32:0]      sn;
  logic [32:0]      cs;
  logic signed [34:0] acc;

  // shared serial unit
  alu_req_t           req;
  logic [ALU_A_W-1:0] alu_a;
  logic [ALU_B_W-1:0] alu_b;
  logic               alu_done;
  logic [ALU_A_W-1:0] res;

  vtd_serial_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (alu_a),
    .b    (alu_b),
    .done (alu_done),
    .res  (res)
  );

  // ---------------- config port ----------------
  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      REG_THROTTLE_LIMIT:      prdata = {7'b0, throttle_limit};
      REG_THROTTLE_SLEW:       prdata = {6'b0, throttle_slew};
      REG_SPEED_LIMIT:         prdata = {8'b0, speed_limit};
      REG_STEER_LIMIT:         prdata = {15'b0, steer_limit};
      REG_STEER_SLEW:          prdata = {12'b0, steer_slew};
      REG_INVERSE_WHEELBASE:   prdata = {12'b0, inverse_wheelbase};
      REG_DRIVE_GAIN_PER_MASS: prdata = drive_gain_per_mass;
      REG_SPEED_DECAY:         prdata = {12'b0, speed_decay};
      default:                 prdata = '0;
    endcase
  end

  // ---------------- throttle move ----------------
  // clamp command to +-limit, then step toward it by at most slew*dt
  logic signed [27:0] t_lim, t_cmd, t_clamp, t_step, t_cur, t_diff, t_dclamp, t_sum;
  logic [THR_W-1:0]   thr_new;

  always_comb begin
    t_lim   = $signed({3'b0, throttle_limit});
    t_cmd   = $signed({{2{tcmd[THR_W-1]}}, tcmd});
    t_cur   = $signed({{2{throttle_state[THR_W-1]}}, throttle_state});
    t_step  = $signed({2'b0, res[41:16]});
    if (t_cmd > t_lim)       t_clamp = t_lim;
    else if (t_cmd < -t_lim) t_clamp = -t_lim;
    else                     t_clamp = t_cmd;
    t_diff = t_clamp - t_cur;
    if (t_diff > t_step)       t_dclamp = t_step;
    else if (t_diff < -t_step) t_dclamp = -t_step;
    else                       t_dclamp = t_diff;
    t_sum   = t_cur + t_dclamp;
    thr_new = t_sum[THR_W-1:0];
  end

  // ---------------- steering move ----------------
  logic signed [21:0] s_lim, s_cmd, s_clamp, s_step, s_cur, s_diff, s_dclamp, s_sum;
  logic [STR_W-1:0]   str_new;

  always_comb begin
    s_lim  = $signed({5'b0, steer_limit});
    s_cmd  = $signed({{4{scmd[STR_W-1]}}, scmd});
    s_cur  = $signed({{4{steer_state[STR_W-1]}}, steer_state});
    s_step = $signed({2'b0, res[35:16]});
    if (s_cmd > s_lim)       s_clamp = s_lim;
    else if (s_cmd < -s_lim) s_clamp = -s_lim;
    else                     s_clamp = s_cmd;
    s_diff = s_clamp - s_cur;
    if (s_diff > s_step)       s_dclamp = s_step;
    else if (s_diff < -s_step) s_dclamp = -s_step;
    else                       s_dclamp = s_diff;
    s_sum   = s_cur + s_dclamp;
    str_new = s_sum[STR_W-1:0];
  end

  // ---------------- series terms ----------------
  // quotient of the last divide is the new term; odd terms subtract
  logic signed [35:0] sum_upd;
  logic [32:0]        e_clamp;
  logic [32:0]        sin_clamp;
  logic [32:0]        cos_clamp;

  always_comb begin
    sum_upd = nidx[0] ? (sum - $signed({3'b0, res[32:0]}))
                      : (sum + $signed({3'b0, res[32:0]}));
    if (sum_upd < 0)                          e_clamp = '0;
    else if (sum_upd > $signed(36'h100000000)) e_clamp = 33'h100000000;
    else                                      e_clamp = sum_upd[32:0];
    sin_clamp = (sum_upd < 0)  ? '0 : sum_upd[32:0];
    cos_clamp = (sum_upd <= 0) ? 33'd1 : sum_upd[32:0];
  end

  // ---------------- acceleration and speed ----------------
  logic signed [34:0] acc_fric;
  logic [34:0]        acc_mag;
  logic signed [36:0] v_ext, dv_ext, v_sum;
  logic [SPD_W-1:0]   speed_new;
  logic [17:0]        st_abs;
  logic [16:0]        st_mag;

  always_comb begin
    acc_fric = acc - $signed({11'b0, res[55:32]});
    acc_mag  = acc_fric[34] ? 35'(-acc_fric) : 35'(acc_fric);
    v_ext    = $signed({13'b0, speed_state});
    dv_ext   = $signed({2'b0, res[50:16]});
    v_sum    = acc[34] ? (v_ext - dv_ext) : (v_ext + dv_ext);
    if (v_sum < 0)                                 speed_new = '0;
    else if (v_sum > $signed({13'b0, speed_limit})) speed_new = speed_limit;
    else                                           speed_new = v_sum[SPD_W-1:0];
    // tangent angle magnitude, held just below pi/2
    st_abs = steer_state[STR_W-1] ? 18'(-steer_state) : steer_state;
    st_mag = (st_abs > {1'b0, TAN_ANGLE_MAX}) ? TAN_ANGLE_MAX : st_abs[16:0];
  end

  // ---------------- yaw saturation ----------------
  logic [YAW_W-1:0] yaw;

  always_comb begin
    if (steer_state[STR_W-1]) begin
      yaw = (res > 64'h1000000) ? 25'h1000000 : 25'(-res[YAW_W-1:0]);
    end else begin
      yaw = (res > 64'hFFFFFF) ? 25'hFFFFFF : res[YAW_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    req        = '{start: 1'b0, op: ALU_MUL};
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          req        = '{start: 1'b1, op: ALU_MUL};
          alu_a      = {38'b0, throttle_slew};
          alu_b      = {17'b0, s_tdata[15:0]};
          ret_next   = ST_TH_MOVE;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (alu_done) state_next = ret;
      end
      ST_TH_MOVE: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {44'b0, steer_slew};
        alu_b      = {17'b0, dt};
        ret_next   = ST_ST_MOVE;
        state_next = ST_WAIT;
      end
      ST_ST_MOVE: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        state_next = ST_WAIT;
        if (!throttle_state[THR_W-1] && (throttle_state != '0)) begin
          alu_a    = {32'b0, drive_gain_per_mass};
          alu_b    = {7'b0, throttle_state};
          ret_next = ST_BASE;
        end else begin
          alu_a    = {32'b0, BRAKE_PER_MASS};
          alu_b    = {7'b0, 26'(-throttle_state)};
          ret_next = ST_BRAKE;
        end
      end
      ST_BASE: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {40'b0, speed_state};
        alu_b      = {13'b0, speed_decay};
        ret_next   = ST_EXP_X;
        state_next = ST_WAIT;
      end
      ST_EXP_X: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        state_next = ST_WAIT;
        if (res[43:32] >= EXP_K_MAX) begin
          alu_a    = {39'b0, base};
          alu_b    = '0;
          ret_next = ST_DRIVE;
        end else begin
          alu_a    = 64'h100000000;
          alu_b    = {17'b0, res[31:16]};
          ret_next = ST_TAY_DIV;
        end
      end
      ST_TAY_DIV: begin
        req        = '{start: 1'b1, op: ALU_DIV};
        alu_a      = {16'b0, res[63:16]};
        alu_b      = {29'b0, nidx};
        ret_next   = ST_TAY_ACC;
        state_next = ST_WAIT;
      end
      ST_TAY_ACC: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        state_next = ST_WAIT;
        if (nidx != EXP_TERMS) begin
          alu_a    = {31'b0, res[32:0]};
          alu_b    = {17'b0, frac};
          ret_next = ST_TAY_DIV;
        end else if (kcnt == '0) begin
          alu_a    = {39'b0, base};
          alu_b    = e_clamp;
          ret_next = ST_DRIVE;
        end else begin
          alu_a    = {31'b0, e_clamp};
          alu_b    = {2'b0, EXP_NEG_ONE};
          ret_next = ST_EXP_POW;
        end
      end
      ST_EXP_POW: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        state_next = ST_WAIT;
        if (kcnt == 5'd1) begin
          alu_a    = {39'b0, base};
          alu_b    = {1'b0, res[63:32]};
          ret_next = ST_DRIVE;
        end else begin
          alu_a    = {32'b0, res[63:32]};
          alu_b    = {2'b0, EXP_NEG_ONE};
          ret_next = ST_EXP_POW;
        end
      end
      ST_DRIVE, ST_BRAKE: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {40'b0, speed_state};
        alu_b      = {9'b0, speed_state};
        ret_next   = ST_DRAG_A;
        state_next = ST_WAIT;
      end
      ST_DRAG_A: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {32'b0, res[47:16]};
        alu_b      = {1'b0, DRAG_PER_MASS};
        ret_next   = ST_DRAG_B;
        state_next = ST_WAIT;
      end
      ST_DRAG_B: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {40'b0, speed_state};
        alu_b      = {1'b0, FRICTION_PER_MASS};
        ret_next   = ST_FRIC;
        state_next = ST_WAIT;
      end
      ST_FRIC: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {29'b0, acc_mag};
        alu_b      = {17'b0, dt};
        ret_next   = ST_SPEED;
        state_next = ST_WAIT;
      end
      ST_SPEED: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {33'b0, st_mag, 14'b0};
        alu_b      = {2'b0, st_mag, 14'b0};
        ret_next   = ST_TRIG_SQ;
        state_next = ST_WAIT;
      end
      ST_TRIG_SQ: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {33'b0, st_mag, 14'b0};
        alu_b      = {1'b0, res[61:30]};
        ret_next   = ST_TRIG_DIV;
        state_next = ST_WAIT;
      end
      ST_TRIG_DIV: begin
        req        = '{start: 1'b1, op: ALU_DIV};
        alu_a      = {30'b0, res[63:30]};
        alu_b      = {24'b0, trig_divisor(cos_mode, nidx)};
        ret_next   = ST_TRIG_ACC;
        state_next = ST_WAIT;
      end
      ST_TRIG_ACC: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        state_next = ST_WAIT;
        if (nidx != TRIG_TERMS) begin
          alu_a    = {31'b0, res[32:0]};
          alu_b    = {1'b0, a2};
          ret_next = ST_TRIG_DIV;
        end else if (!cos_mode) begin
          alu_a    = 64'h40000000;
          alu_b    = {1'b0, a2};
          ret_next = ST_TRIG_DIV;
        end else begin
          alu_a    = {40'b0, speed_state};
          alu_b    = {13'b0, inverse_wheelbase};
          ret_next = ST_YAW_P;
        end
      end
      ST_YAW_P: begin
        req        = '{start: 1'b1, op: ALU_MUL};
        alu_a      = {36'b0, res[43:16]};
        alu_b      = sn;
        ret_next   = ST_YAW_Q;
        state_next = ST_WAIT;
      end
      ST_YAW_Q: begin
        req        = '{start: 1'b1, op: ALU_DIV};
        alu_a      = res;
        alu_b      = cs;
        ret_next   = ST_DONE;
        state_next = ST_WAIT;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_limit      <= THROTTLE_LIMIT_RST;
      throttle_slew       <= THROTTLE_SLEW_RST;
      speed_limit         <= SPEED_LIMIT_RST;
      steer_limit         <= STEER_LIMIT_RST;
      steer_slew          <= STEER_SLEW_RST;
      inverse_wheelbase   <= INVERSE_WHEELBASE_RST;
      drive_gain_per_mass <= DRIVE_GAIN_PER_MASS_RST;
      speed_decay         <= SPEED_DECAY_RST;
      throttle_state      <= '0;
      steer_state         <= '0;
      speed_state         <= '0;
      m_tvalid            <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_THROTTLE_LIMIT:      throttle_limit      <= pwdata[24:0];
          REG_THROTTLE_SLEW:       throttle_slew       <= pwdata[25:0];
          REG_SPEED_LIMIT:         speed_limit         <= pwdata[23:0];
          REG_STEER_LIMIT:         steer_limit         <= pwdata[16:0];
          REG_STEER_SLEW:          steer_slew          <= pwdata[19:0];
          REG_INVERSE_WHEELBASE:   inverse_wheelbase   <= pwdata[19:0];
          REG_DRIVE_GAIN_PER_MASS: drive_gain_per_mass <= pwdata;
          REG_SPEED_DECAY:         speed_decay         <= pwdata[19:0];
          default: ;
        endcase
      end
      if (state == ST_TH_MOVE) throttle_state <= thr_new;
      if (state == ST_ST_MOVE) steer_state    <= str_new;
      if (state == ST_SPEED)   speed_state    <= speed_new;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          dt   <= s_tdata[15:0];
          tcmd <= s_tdata[41:16];
          scmd <= s_tdata[59:42];
        end
      end
      ST_BASE: base <= res[56:32];
      ST_EXP_X: begin
        kcnt <= res[36:32];
        frac <= res[31:16];
        sum  <= 36'sh100000000;
        nidx <= 4'd1;
      end
      ST_TAY_ACC: begin
        sum  <= sum_upd;
        nidx <= nidx + 4'd1;
      end
      ST_EXP_POW: kcnt <= kcnt - 5'd1;
      ST_DRIVE:   acc  <= $signed({9'b0, res[57:32]});
      ST_BRAKE:   acc  <= -$signed({9'b0, res[57:32]});
      ST_DRAG_B:  acc  <= acc - $signed({3'b0, res[63:32]});
      ST_FRIC:    acc  <= acc_fric;
      ST_TRIG_SQ: begin
        a2       <= res[61:30];
        sum      <= $signed({5'b0, st_mag, 14'b0});
        nidx     <= 4'd1;
        cos_mode <= 1'b0;
      end
      ST_TRIG_ACC: begin
        if (nidx != TRIG_TERMS) begin
          sum  <= sum_upd;
          nidx <= nidx + 4'd1;
        end else if (!cos_mode) begin
          sn       <= sin_clamp;
          sum      <= 36'sh40000000;
          nidx     <= 4'd1;
          cos_mode <= 1'b1;
        end else begin
          cs <= cos_clamp;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {3'b0, yaw, speed_state, steer_state, throttle_state};
        end
      end
      default: ;
    endcase
  end

endmodule
